// ===== rtl/msam_pkg.sv =====
`timescale 1ns / 1ps

package msam_pkg;

  localparam int OP_W     = 2;
  localparam int SLOT_W   = 4;
  localparam int YEAR_W   = 16;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int HOUR_W   = 5;
  localparam int MINUTE_W = 6;
  localparam int MASK_W   = 8;

  typedef enum logic [OP_W-1:0] {
    OP_TICK   = 2'd0,
    OP_SET    = 2'd1,
    OP_DELETE = 2'd2
  } op_e;

  typedef struct packed {
    logic [OP_W-1:0]     opcode;
    logic [SLOT_W-1:0]   slot;
    logic [YEAR_W-1:0]   year_value;
    logic [MONTH_W-1:0]  month_value;
    logic [DAY_W-1:0]    day_value;
    logic [HOUR_W-1:0]   hour_value;
    logic [MINUTE_W-1:0] minute_value;
    logic                daily_mode;
  } item_t;

  typedef struct packed {
    logic load_item;
    logic update;
    logic scan_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic is_tick;
    logic scan_last;
  } status_t;

endpackage

// ===== rtl/msam_ctrl.sv =====
`timescale 1ns / 1ps

module msam_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  msam_pkg::status_t  status_i,
  output msam_pkg::cmd_t     cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_DONE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    out_valid_d   = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (status_i.is_tick) begin
          cmd_o.scan_step = 1'b1;
          state_d         = status_i.scan_last ? ST_DONE : ST_SCAN;
        end else begin
          cmd_o.update = 1'b1;
          state_d      = ST_DONE;
        end
      end
      ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (status_i.scan_last) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== rtl/msam_datapath.sv =====
`timescale 1ns / 1ps

module msam_datapath #(
  parameter int NUM_SLOTS = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  msam_pkg::item_t               item_i,
  input  msam_pkg::cmd_t                cmd_i,
  output msam_pkg::status_t             status_o,
  output logic [msam_pkg::MASK_W-1:0]   fired_mask_o,
  output logic                          accepted_o
);

  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  msam_pkg::item_t item_q;
  logic [IDX_W-1:0] idx_q;
  logic [msam_pkg::MASK_W-1:0] fired_q;
  logic [msam_pkg::MASK_W-1:0] out_mask_q;
  logic out_acc_q;

  logic                            en_q     [NUM_SLOTS];
  logic                            lock_v_q [NUM_SLOTS];
  logic                            daily_q  [NUM_SLOTS];
  logic [msam_pkg::YEAR_W-1:0]     year_q   [NUM_SLOTS];
  logic [msam_pkg::MONTH_W-1:0]    month_q  [NUM_SLOTS];
  logic [msam_pkg::DAY_W-1:0]      day_q    [NUM_SLOTS];
  logic [msam_pkg::HOUR_W-1:0]     hour_q   [NUM_SLOTS];
  logic [msam_pkg::MINUTE_W-1:0]   minute_q [NUM_SLOTS];
  logic [msam_pkg::DAY_W-1:0]      lock_day_q [NUM_SLOTS];

  logic is_tick, is_set, is_delete, in_range, accepted;
  logic [IDX_W-1:0] wr_idx;
  logic time_match, date_match, locked_today, hit_daily, hit_once;

  assign is_tick   = (item_q.opcode == msam_pkg::OP_TICK);
  assign is_set    = (item_q.opcode == msam_pkg::OP_SET);
  assign is_delete = (item_q.opcode == msam_pkg::OP_DELETE);
  assign in_range  = (item_q.slot < msam_pkg::SLOT_W'(NUM_SLOTS));
  assign accepted  = is_tick || ((is_set || is_delete) && in_range);
  assign wr_idx    = item_q.slot[IDX_W-1:0];

  assign time_match   = (hour_q[idx_q] == item_q.hour_value) &&
                        (minute_q[idx_q] == item_q.minute_value);
  assign date_match   = (year_q[idx_q] == item_q.year_value) &&
                        (month_q[idx_q] == item_q.month_value) &&
                        (day_q[idx_q] == item_q.day_value);
  assign locked_today = lock_v_q[idx_q] && (lock_day_q[idx_q] == item_q.day_value);
  assign hit_daily    = en_q[idx_q] && daily_q[idx_q] && time_match && !locked_today;
  assign hit_once     = en_q[idx_q] && !daily_q[idx_q] && time_match && date_match;

  assign status_o.is_tick   = is_tick;
  assign status_o.scan_last = (idx_q == IDX_W'(NUM_SLOTS - 1));
  assign fired_mask_o       = out_mask_q;
  assign accepted_o         = out_acc_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      item_q <= item_i;
    end
    if (cmd_i.update && in_range && is_set) begin
      daily_q[wr_idx]  <= item_q.daily_mode;
      year_q[wr_idx]   <= item_q.year_value;
      month_q[wr_idx]  <= item_q.month_value;
      day_q[wr_idx]    <= item_q.day_value;
      hour_q[wr_idx]   <= item_q.hour_value;
      minute_q[wr_idx] <= item_q.minute_value;
    end
    if (cmd_i.scan_step && hit_daily) begin
      lock_day_q[idx_q] <= item_q.day_value;
    end
    if (cmd_i.load_out) begin
      out_mask_q <= fired_q;
      out_acc_q  <= accepted;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      fired_q <= '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        en_q[i]     <= 1'b0;
        lock_v_q[i] <= 1'b0;
      end
    end else begin
      if (cmd_i.load_item) begin
        idx_q   <= '0;
        fired_q <= '0;
      end
      if (cmd_i.update && in_range) begin
        if (is_set) begin
          en_q[wr_idx]     <= 1'b1;
          lock_v_q[wr_idx] <= 1'b0;
        end else if (is_delete) begin
          en_q[wr_idx] <= 1'b0;
        end
      end
      if (cmd_i.scan_step) begin
        idx_q <= idx_q + IDX_W'(1);
        if (hit_daily) begin
          lock_v_q[idx_q] <= 1'b1;
        end
        if (hit_once) begin
          en_q[idx_q] <= 1'b0;
        end
        if (hit_daily || hit_once) begin
          fired_q <= fired_q | (msam_pkg::MASK_W'(1) << idx_q);
        end
      end
    end
  end

`ifndef SYNTH
  a_cmd_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.update && cmd_i.scan_step))
    else $error("Slot update and scan step issued together.");

  a_oneshot_disables: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scan_step && hit_once |=> !en_q[$past(idx_q)])
    else $error("One-shot slot still enabled after it fired.");

  a_mask_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_mask_q >> NUM_SLOTS) == '0 || !out_acc_q)
    else $error("Fired mask has a bit beyond the last slot.");

  a_nontick_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out && !is_tick |=> out_mask_q == '0)
    else $error("Set or delete result carries a nonzero fired mask.");
`endif

endmodule

// ===== rtl/multi_slot_alarm_matcher.sv =====
`timescale 1ns / 1ps
// A tick request is checked against one alarm slot per cycle, the slots in order,
// and its result is registered after the last slot is checked. A set or delete
// request updates its slot if the slot is in range and then registers its result.
// A new request is taken only once the last result is in the output register, where it waits.
// Reset is asynchronous and active low; it disables and unlocks every slot.

module multi_slot_alarm_matcher #(
  parameter int NUM_SLOTS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // slot, year_value, month_value, day_value, hour_value, minute_value, daily_mode
  input  logic [47:0] s_axis_tdata,
  // opcode
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // fired_mask, accepted
  output logic [15:0] m_axis_tdata
);

  msam_pkg::item_t   item;
  msam_pkg::cmd_t    cmd;
  msam_pkg::status_t status;
  logic [msam_pkg::MASK_W-1:0] fired_mask;
  logic accepted;

  assign item.opcode       = s_axis_tuser;
  assign item.slot         = s_axis_tdata[3:0];
  assign item.year_value   = s_axis_tdata[19:4];
  assign item.month_value  = s_axis_tdata[23:20];
  assign item.day_value    = s_axis_tdata[28:24];
  assign item.hour_value   = s_axis_tdata[33:29];
  assign item.minute_value = s_axis_tdata[39:34];
  assign item.daily_mode   = s_axis_tdata[40];

  assign m_axis_tdata = {7'd0, accepted, fired_mask};

  msam_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  msam_datapath #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (item),
    .cmd_i        (cmd),
    .status_o     (status),
    .fired_mask_o (fired_mask),
    .accepted_o   (accepted)
  );

endmodule

// ===== tb/sv/multi_slot_alarm_matcher_tb.sv =====
`timescale 1ns / 1ps

module multi_slot_alarm_matcher_tb;

  localparam int NUM_SLOTS = 8;
  localparam int RANDOM_ITEMS = 1575;
  localparam int LONG_HOLD_AT = 400;
  localparam int DRAIN_AT = 800;
  localparam int TAIL_FROM = RANDOM_ITEMS - 200;
  localparam logic [msam_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;

  msam_pkg::item_t offered_req;
  bit    long_hold_req = 1'b0;
  bit    quiet_tail = 1'b0;

  class alarm_fire_board;
    typedef struct {
      logic [msam_pkg::MASK_W-1:0] mask;
      logic                        accepted;
    } fire_result_t;

    msam_pkg::item_t            alarm_slot[NUM_SLOTS];
    bit                         slot_on[NUM_SLOTS];
    bit                         locked[NUM_SLOTS];
    logic [msam_pkg::DAY_W-1:0] lock_dom[NUM_SLOTS];
    fire_result_t               expected_fires[$];
    int                         failures;

    function new();
      for (int i = 0; i < NUM_SLOTS; i++) begin
        alarm_slot[i] = '0;
        slot_on[i] = 1'b0;
        locked[i] = 1'b0;
        lock_dom[i] = '0;
      end
      failures = 0;
    endfunction

    function void predict_fires(msam_pkg::item_t req);
      fire_result_t res;
      res.mask = '0;
      res.accepted = 1'b0;
      case (req.opcode)
        msam_pkg::OP_TICK: begin
          res.accepted = 1'b1;
          for (int i = 0; i < NUM_SLOTS; i++) begin
            if (slot_on[i]) begin
              if (alarm_slot[i].daily_mode) begin
                if (alarm_slot[i].hour_value == req.hour_value &&
                    alarm_slot[i].minute_value == req.minute_value &&
                    !(locked[i] && lock_dom[i] == req.day_value)) begin
                  res.mask[i] = 1'b1;
                  locked[i] = 1'b1;
                  lock_dom[i] = req.day_value;
                end
              end else if (alarm_slot[i].year_value == req.year_value &&
                           alarm_slot[i].month_value == req.month_value &&
                           alarm_slot[i].day_value == req.day_value &&
                           alarm_slot[i].hour_value == req.hour_value &&
                           alarm_slot[i].minute_value == req.minute_value) begin
                res.mask[i] = 1'b1;
                slot_on[i] = 1'b0;
              end
            end
          end
        end
        msam_pkg::OP_SET: begin
          if (req.slot < NUM_SLOTS) begin
            alarm_slot[req.slot] = req;
            slot_on[req.slot] = 1'b1;
            locked[req.slot] = 1'b0;
            lock_dom[req.slot] = '0;
            res.accepted = 1'b1;
          end
        end
        msam_pkg::OP_DELETE: begin
          if (req.slot < NUM_SLOTS) begin
            slot_on[req.slot] = 1'b0;
            res.accepted = 1'b1;
          end
        end
        default: begin
        end
      endcase
      expected_fires.push_back(res);
    endfunction

    function void compare_fires(logic [15:0] data);
      fire_result_t exp_res;
      if (expected_fires.size() == 0) begin
        $error("result %h arrived with no request outstanding", data);
        failures++;
        return;
      end
      exp_res = expected_fires.pop_front();
      if (data[msam_pkg::MASK_W-1:0] !== exp_res.mask) begin
        $error("fired_mask: expected %h, actual %h", exp_res.mask,
               data[msam_pkg::MASK_W-1:0]);
        failures++;
      end
      if (data[msam_pkg::MASK_W] !== exp_res.accepted) begin
        $error("accepted: expected %b, actual %b", exp_res.accepted,
               data[msam_pkg::MASK_W]);
        failures++;
      end
    endfunction

    function int open_count();
      return expected_fires.size();
    endfunction
  endclass

  alarm_fire_board board;

  multi_slot_alarm_matcher #(
    .NUM_SLOTS(NUM_SLOTS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      board.predict_fires(offered_req);
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      board.compare_fires(m_axis_tdata);
    end
  end

  initial begin
    int stall_left;
    stall_left = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall_left = 400;
      end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 18);
      end
      m_axis_tready <= (stall_left == 0);
    end
  end

  initial begin
    #5000000;
    $display("multi_slot_alarm_matcher_tb NOT OK");
    $finish;
  end

  function automatic msam_pkg::item_t make_item(logic [msam_pkg::OP_W-1:0] op, int slot,
                                                int yr, int mo, int dy, int hr, int mn,
                                                bit dm);
    msam_pkg::item_t it;
    it.opcode = op;
    it.slot = msam_pkg::SLOT_W'(slot);
    it.year_value = msam_pkg::YEAR_W'(yr);
    it.month_value = msam_pkg::MONTH_W'(mo);
    it.day_value = msam_pkg::DAY_W'(dy);
    it.hour_value = msam_pkg::HOUR_W'(hr);
    it.minute_value = msam_pkg::MINUTE_W'(mn);
    it.daily_mode = dm;
    return it;
  endfunction

  function automatic msam_pkg::item_t random_fields();
    return make_item(msam_pkg::OP_W'($urandom_range(0, 3)), $urandom_range(0, 15),
                     $urandom_range(0, 65535), $urandom_range(0, 15), $urandom_range(0, 31),
                     $urandom_range(0, 31), $urandom_range(0, 63), $urandom_range(0, 1));
  endfunction

  function automatic logic [msam_pkg::DAY_W-1:0] pool_day();
    return ($urandom_range(0, 3) == 0) ? 5'd31 : 5'($urandom_range(1, 3));
  endfunction

  function automatic msam_pkg::item_t pool_item(logic [msam_pkg::OP_W-1:0] op);
    msam_pkg::item_t it;
    it = random_fields();
    it.opcode = op;
    it.slot = msam_pkg::SLOT_W'($urandom_range(0, NUM_SLOTS - 1));
    case ($urandom_range(0, 3))
      0:       it.year_value = '0;
      1:       it.year_value = '1;
      default: it.year_value = 16'd2024 + 16'($urandom_range(0, 1));
    endcase
    it.month_value = ($urandom_range(0, 2) == 0) ? 4'd15 : 4'($urandom_range(1, 2));
    it.day_value = pool_day();
    case ($urandom_range(0, 3))
      0:       it.hour_value = 5'd0;
      1:       it.hour_value = 5'd23;
      2:       it.hour_value = 5'd31;
      default: it.hour_value = 5'($urandom_range(0, 23));
    endcase
    case ($urandom_range(0, 3))
      0:       it.minute_value = 6'd0;
      1:       it.minute_value = 6'd59;
      2:       it.minute_value = 6'd63;
      default: it.minute_value = 6'($urandom_range(0, 59));
    endcase
    return it;
  endfunction

  task automatic send_request(msam_pkg::item_t req);
    @(negedge clk_i);
    offered_req = req;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= req.opcode;
    s_axis_tdata <= {7'd0, req.daily_mode, req.minute_value, req.hour_value, req.day_value,
                     req.month_value, req.year_value, req.slot};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic source_idle(int cycles);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    repeat (cycles) @(negedge clk_i);
  endtask

  task automatic wait_all_fired();
    source_idle(1);
    while (board.open_count() != 0) @(posedge clk_i);
  endtask

  initial begin
    msam_pkg::item_t last_set[NUM_SLOTS];
    msam_pkg::item_t req;
    int    roll;
    board = new();
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    send_request(make_item(msam_pkg::OP_TICK, 0, 0, 0, 0, 0, 0, 0));
    send_request(make_item(msam_pkg::OP_SET, 0, 2024, 3, 10, 7, 30, 1));
    send_request(make_item(msam_pkg::OP_SET, 7, 65535, 15, 31, 31, 63, 0));
    send_request(make_item(msam_pkg::OP_SET, 9, 2024, 3, 10, 7, 30, 1));
    send_request(make_item(msam_pkg::OP_DELETE, 15, 0, 0, 0, 0, 0, 0));
    send_request(make_item(OP_UNUSED, 15, 65535, 15, 31, 31, 63, 1));
    send_request(make_item(msam_pkg::OP_TICK, 0, 2024, 3, 10, 7, 30, 0));
    send_request(make_item(msam_pkg::OP_TICK, 0, 2024, 3, 10, 7, 30, 0));
    send_request(make_item(msam_pkg::OP_TICK, 0, 2024, 3, 11, 7, 30, 0));
    send_request(make_item(msam_pkg::OP_TICK, 15, 65535, 15, 31, 31, 63, 1));
    send_request(make_item(msam_pkg::OP_TICK, 15, 65535, 15, 31, 31, 63, 1));
    send_request(make_item(msam_pkg::OP_DELETE, 0, 0, 0, 0, 0, 0, 0));
    send_request(make_item(msam_pkg::OP_TICK, 0, 2024, 3, 12, 7, 30, 0));
    send_request(make_item(msam_pkg::OP_SET, 0, 2024, 3, 10, 7, 30, 1));
    send_request(make_item(msam_pkg::OP_TICK, 0, 2024, 3, 11, 7, 30, 0));
    send_request(make_item(msam_pkg::OP_SET, 1, 0, 0, 0, 0, 0, 0));
    send_request(make_item(msam_pkg::OP_SET, 2, 0, 0, 0, 0, 0, 1));
    send_request(make_item(msam_pkg::OP_SET, 3, 2024, 3, 11, 7, 30, 0));
    send_request(make_item(msam_pkg::OP_TICK, 0, 0, 0, 0, 0, 0, 0));
    send_request(make_item(msam_pkg::OP_TICK, 0, 2024, 3, 11, 7, 30, 0));
    send_request(make_item(msam_pkg::OP_DELETE, 3, 0, 0, 0, 0, 0, 0));
    send_request(make_item(msam_pkg::OP_SET, 4, 1, 1, 1, 31, 63, 1));
    send_request(make_item(msam_pkg::OP_TICK, 0, 0, 0, 0, 31, 63, 0));
    send_request(make_item(msam_pkg::OP_DELETE, 1, 0, 0, 0, 0, 0, 0));
    send_request(make_item(msam_pkg::OP_TICK, 0, 0, 0, 0, 0, 0, 0));
    wait_all_fired();

    for (int i = 0; i < NUM_SLOTS; i++) begin
      last_set[i] = pool_item(msam_pkg::OP_SET);
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == TAIL_FROM) begin
        quiet_tail = 1'b1;
      end
      if (n == DRAIN_AT) begin
        wait_all_fired();
      end
      if (!quiet_tail && $urandom_range(0, 5) == 0) begin
        source_idle($urandom_range(1, 18));
      end
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
        if ($urandom_range(0, 2) != 0) begin
          req = last_set[$urandom_range(0, NUM_SLOTS - 1)];
          req.opcode = msam_pkg::OP_TICK;
          if ($urandom_range(0, 2) == 0) begin
            req.day_value = pool_day();
          end
        end else begin
          req = pool_item(msam_pkg::OP_TICK);
        end
      end else if (roll < 80) begin
        req = pool_item(msam_pkg::OP_SET);
        last_set[req.slot] = req;
      end else if (roll < 88) begin
        req = pool_item(msam_pkg::OP_DELETE);
      end else begin
        req = random_fields();
      end
      send_request(req);
      if (n == LONG_HOLD_AT) begin
        long_hold_req = 1'b1;
      end
    end

    source_idle(1);
    while (board.open_count() != 0) @(posedge clk_i);
    repeat (2 * NUM_SLOTS + 4) @(posedge clk_i);
    if (board.failures == 0) begin
      $display("multi_slot_alarm_matcher_tb OK");
    end else begin
      $display("multi_slot_alarm_matcher_tb NOT OK");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/msam_pkg.sv
rtl/msam_ctrl.sv
rtl/msam_datapath.sv
rtl/multi_slot_alarm_matcher.sv
tb/sv/multi_slot_alarm_matcher_tb.sv
